// ===== sv/tca_pkg.sv =====
// Shared types, constants and the command mapping function for the thruster
// control allocation block. No dependencies.
`timescale 1ns / 1ps

package tca_pkg;

    localparam int AXES     = 6;
    localparam int CMD_W    = 8;
    localparam int CMDQ_W   = 17;
    localparam int COEF_W   = 16;
    localparam int SUM_W    = 32;
    localparam int DEN_W    = 32;
    localparam int T_W      = DEN_W + 1;
    localparam int SPAN_W   = 12;
    localparam int NUM_W    = T_W + SPAN_W + 1;
    localparam int DVS_W    = DEN_W + 1;
    localparam int QUO_W    = 12;
    localparam int DZ_W     = 15;
    localparam int PULSE_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [DEN_W-1:0] DEN_MIN = DEN_W'(1) << 28;

    localparam logic [DZ_W-1:0]    DZ_RESET    = DZ_W'(1638);
    localparam logic [PULSE_W-1:0] MIN_RESET   = PULSE_W'(1000);
    localparam logic [PULSE_W-1:0] MAX_RESET   = PULSE_W'(2000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE  = 2'd0,
        CFG_MIN_PULSE = 2'd1,
        CFG_MAX_PULSE = 2'd2
    } cfg_index_t;

    typedef logic signed [CMDQ_W-1:0] cmdq_t;
    typedef cmdq_t cmd_vec_t [AXES];
    typedef logic signed [COEF_W-1:0] coef_row_t [AXES];
    typedef logic [DEN_W-1:0] mag_vec_t [AXES];

    localparam logic signed [COEF_W-1:0] ALLOC [AXES][AXES] = '{
        '{   16'sd19,  16'sd4096,   -16'sd22,   -16'sd130,  16'sd24325, -16'sd29480 },
        '{  -16'sd19,  16'sd4096,    16'sd22,    16'sd130, -16'sd24325,  16'sd29480 },
        '{ -16'sd2907,    16'sd2,  16'sd2909, -16'sd19224, -16'sd15932,      16'sd0 },
        '{  16'sd2882,   -16'sd2,  16'sd2909,  16'sd19394, -16'sd15932,      16'sd0 },
        '{ -16'sd2885,   -16'sd2,  16'sd2884,  16'sd19224,  16'sd15932,      16'sd0 },
        '{  16'sd2911,    16'sd2,  16'sd2884, -16'sd19394,  16'sd15932,      16'sd0 }
    };

    typedef struct packed {
        logic [CMD_W-1:0] cmd_surge;
        logic [CMD_W-1:0] cmd_sway;
        logic [CMD_W-1:0] cmd_heave;
        logic [CMD_W-1:0] cmd_roll;
        logic [CMD_W-1:0] cmd_pitch;
        logic [CMD_W-1:0] cmd_yaw;
    } cmd_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_0;
        logic [PULSE_W-1:0] pulse_1;
        logic [PULSE_W-1:0] pulse_2;
        logic [PULSE_W-1:0] pulse_3;
        logic [PULSE_W-1:0] pulse_4;
        logic [PULSE_W-1:0] pulse_5;
    } pulse_t;

    // (2u-255)*32768/255 rounded, saturated, then deadzone
    function automatic cmdq_t map_cmd(input logic [CMD_W-1:0] u, input logic [DZ_W-1:0] dz);
        logic        pos;
        logic [7:0]  x;
        logic [15:0] v;
        logic [15:0] q;
        logic [15:0] mag;
        cmdq_t       res;
        pos = u[7];
        x   = {(pos ? u[6:0] : ~u[6:0]), 1'b1};
        v   = {1'b0, x, 7'd0} + 16'd127;
        q   = (v + (v >> 8) + 16'd1) >> 8;
        mag = {1'b0, x, 7'd0} + q;
        if (pos && mag[15])
            mag = 16'd32767;
        if (mag < {1'b0, dz})
            mag = 16'd0;
        res = pos ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
        return res;
    endfunction

endpackage

// ===== sv/tca_sum_lane.sv =====
// One allocation row: six constant products, then the row sum and its magnitude.
// Depends on tca_pkg.
`timescale 1ns / 1ps

module tca_sum_lane (
    input  logic                                clk,
    input  logic                                adv,
    input  tca_pkg::cmd_vec_t                   cmd_vec,
    input  tca_pkg::coef_row_t                  coef,
    output logic signed [tca_pkg::SUM_W-1:0]    sum,
    output logic [tca_pkg::DEN_W-1:0]           mag
);
    import tca_pkg::*;

    logic signed [SUM_W-1:0] prod_reg [AXES];
    logic signed [SUM_W-1:0] prod_next [AXES];
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [DEN_W-1:0]        mag_reg;
    logic [DEN_W-1:0]        mag_next;

    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            prod_next[j] = SUM_W'(cmd_vec[j] * coef[j]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < AXES; j++)
        begin
            sum_next = sum_next + prod_reg[j];
        end
        mag_next = sum_next[SUM_W-1] ? DEN_W'(-sum_next) : DEN_W'(sum_next);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            mag_reg  <= mag_next;
        end
    end

    assign sum = sum_reg;
    assign mag = mag_reg;

endmodule

// ===== sv/tca_peak.sv =====
// Merge stage: largest force magnitude across all rows, floored at unity.
// Depends on tca_pkg.
`timescale 1ns / 1ps

module tca_peak (
    input  logic                        clk,
    input  logic                        adv,
    input  tca_pkg::mag_vec_t           mag,
    output logic [tca_pkg::DEN_W-1:0]   den
);
    import tca_pkg::*;

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;

    always_comb
    begin
        den_next = DEN_MIN;
        for (int i = 0; i < AXES; i++)
        begin
            if (mag[i] > den_next)
                den_next = mag[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            den_reg <= den_next;
    end

    assign den = den_reg;

endmodule

// ===== sv/tca_pulse_lane.sv =====
// One thruster: offset, scale by pulse span, then a pipelined restoring divide
// by twice the denominator, one quotient bit per stage. Depends on tca_pkg.
`timescale 1ns / 1ps

module tca_pulse_lane (
    input  logic                                clk,
    input  logic                                adv,
    input  logic signed [tca_pkg::SUM_W-1:0]    sum,
    input  logic [tca_pkg::DEN_W-1:0]           den,
    input  logic [tca_pkg::SPAN_W-1:0]          span_mag,
    output logic [tca_pkg::QUO_W-1:0]           quo
);
    import tca_pkg::*;

    logic signed [SUM_W-1:0] s_reg;
    logic [T_W-1:0]          t_reg;
    logic [T_W-1:0]          t_next;
    logic [DEN_W-1:0]        den_b_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [NUM_W-1:0]        num_next;
    logic [DVS_W-1:0]        dvs_reg;
    logic signed [T_W:0]     tsum;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DVS_W-1:0] dvs_pipe_reg [QUO_W];

    always_comb
    begin
        tsum     = {{2{s_reg[SUM_W-1]}}, s_reg} + $signed({2'b00, den});
        t_next   = tsum[T_W-1:0];
        num_next = NUM_W'(t_reg * span_mag) + NUM_W'(den_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg     <= sum;
            t_reg     <= t_next;
            den_b_reg <= den;
            num_reg   <= num_next;
            dvs_reg   <= {den_b_reg, 1'b0};
        end
    end

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        localparam int BIT = QUO_W - 1 - i;
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DVS_W-1:0] dvs_in;
        logic [NUM_W-1:0] trial;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (i == 0)
        begin : g_first
            assign rem_in = num_reg;
            assign quo_in = '0;
            assign dvs_in = dvs_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign dvs_in = dvs_pipe_reg[i-1];
        end

        always_comb
        begin
            trial    = NUM_W'(dvs_in) << BIT;
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= trial)
            begin
                rem_next      = rem_in - trial;
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]      <= rem_next;
                quo_reg[i]      <= quo_next;
                dvs_pipe_reg[i] <= dvs_in;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

// ===== sv/thruster_control_allocation.sv =====
// Thruster control allocation top level: config registers, command mapping,
// six sum lanes, peak merge, six pulse lanes and the output register.
// Depends on tca_pkg, tca_sum_lane, tca_peak, tca_pulse_lane.
`timescale 1ns / 1ps

// Takes one six-axis command per cycle and returns six thruster pulse widths,
// one transaction in and one out per cycle when the output is not stalled. Each
// command passes through the row products and sums, the peak merge, the span
// scaling and the twelve-stage divide by the denominator in each thruster lane.
// A stall on the output holds the whole pipeline, so cmd_stall follows
// pulse_stall while a result waits. Configuration writes are always taken and
// must only be issued while no transaction is in flight.
module thruster_control_allocation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  tca_pkg::cmd_t                        cmd,
    output logic                                 pulse_valid,
    input  logic                                 pulse_stall,
    output tca_pkg::pulse_t                      pulse,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tca_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tca_pkg::*;

    localparam int PIPE_DEPTH = 6 + QUO_W;

    logic [DZ_W-1:0]       dz_reg;
    logic [PULSE_W-1:0]    min_reg;
    logic [PULSE_W-1:0]    max_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  pulse_valid_reg;
    pulse_t                pulse_reg;
    pulse_t                pulse_next;
    cmd_vec_t              cmd_reg;
    cmd_vec_t              cmd_next;
    logic                  adv;
    logic                  accept;

    logic signed [SUM_W-1:0] sum_lane [AXES];
    mag_vec_t                mag_lane;
    logic [DEN_W-1:0]        den;
    logic [QUO_W-1:0]        quo_lane [AXES];
    logic [PULSE_W-1:0]      pw [AXES];
    logic signed [PULSE_W:0] span;
    logic                    span_neg;
    logic [SPAN_W-1:0]       span_mag;

    assign adv       = !pulse_valid_reg || !pulse_stall;
    assign accept    = cmd_valid && adv;
    assign cmd_stall = !adv;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        span     = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
        span_neg = span[PULSE_W];
        span_mag = span_neg ? SPAN_W'(-span) : SPAN_W'(span);
    end

    always_comb
    begin
        cmd_next[0] = map_cmd(cmd.cmd_surge, dz_reg);
        cmd_next[1] = map_cmd(cmd.cmd_sway,  dz_reg);
        cmd_next[2] = map_cmd(cmd.cmd_heave, dz_reg);
        cmd_next[3] = map_cmd(cmd.cmd_roll,  dz_reg);
        cmd_next[4] = map_cmd(cmd.cmd_pitch, dz_reg);
        cmd_next[5] = map_cmd(cmd.cmd_yaw,   dz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            cmd_reg <= cmd_next;
    end

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        tca_sum_lane u_sum (
            .clk     (clk),
            .adv     (adv),
            .cmd_vec (cmd_reg),
            .coef    (ALLOC[i]),
            .sum     (sum_lane[i]),
            .mag     (mag_lane[i])
        );

        tca_pulse_lane u_pulse (
            .clk      (clk),
            .adv      (adv),
            .sum      (sum_lane[i]),
            .den      (den),
            .span_mag (span_mag),
            .quo      (quo_lane[i])
        );

        assign pw[i] = span_neg ? min_reg - quo_lane[i] : min_reg + quo_lane[i];
    end

    tca_peak u_peak (
        .clk (clk),
        .adv (adv),
        .mag (mag_lane),
        .den (den)
    );

    always_comb
    begin
        pulse_next.pulse_0 = pw[0];
        pulse_next.pulse_1 = pw[1];
        pulse_next.pulse_2 = pw[2];
        pulse_next.pulse_3 = pw[3];
        pulse_next.pulse_4 = pw[4];
        pulse_next.pulse_5 = pw[5];
        valid_next = {valid_reg[PIPE_DEPTH-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg          <= DZ_RESET;
            min_reg         <= MIN_RESET;
            max_reg         <= MAX_RESET;
            valid_reg       <= '0;
            pulse_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DEADZONE:  dz_reg  <= cfg_data[DZ_W-1:0];
                    CFG_MIN_PULSE: min_reg <= cfg_data[PULSE_W-1:0];
                    CFG_MAX_PULSE: max_reg <= cfg_data[PULSE_W-1:0];
                    default: ;
                endcase
            end
            if (adv)
            begin
                valid_reg       <= valid_next;
                pulse_valid_reg <= valid_reg[PIPE_DEPTH-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pulse_reg <= pulse_next;
    end

    assign pulse_valid = pulse_valid_reg;
    assign pulse       = pulse_reg;

    // hold the pipeline while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_valid && pulse_stall) |=> $stable(valid_reg))
        else $error("pipeline moved while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_valid && !span_neg) |->
        (pulse.pulse_0 >= min_reg && pulse.pulse_0 <= max_reg))
        else $error("pulse_0 outside limits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_valid && span_neg) |->
        (pulse.pulse_5 <= min_reg && pulse.pulse_5 >= max_reg))
        else $error("pulse_5 outside reversed limits");

    assert property (@(posedge clk) disable iff (!rst_n)
        den >= DEN_MIN || $countones(valid_reg) == 0 || !valid_reg[3])
        else $error("denominator below unity");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for thruster_control_allocation: random and directed wrench commands
// checked against a scoreboard that predicts the six pulse widths.
// Depends on tca_pkg and the thruster_control_allocation RTL.
`timescale 1ns / 1ps

class pulse_scoreboard;
    tca_pkg::pulse_t expected_q[$];
    logic [14:0] deadzone;
    logic [11:0] min_us;
    logic [11:0] max_us;
    int errors;

    function new();
        deadzone = 15'd1638;
        min_us = 12'd1000;
        max_us = 12'd2000;
        errors = 0;
    endfunction

    function void set_reg(tca_pkg::cfg_index_t idx, logic [14:0] value);
        case (idx)
            tca_pkg::CFG_DEADZONE: deadzone = value;
            tca_pkg::CFG_MIN_PULSE: min_us = value[11:0];
            tca_pkg::CFG_MAX_PULSE: max_us = value[11:0];
            default: ;
        endcase
    endfunction

    function longint scale_byte(logic [7:0] u);
        longint num;
        longint m;
        longint mag;
        num = (2 * longint'(u) - 255) * 32768;
        if (num >= 0)
            m = (num + 127) / 255;
        else
            m = -((-num + 127) / 255);
        if (m > 32767)
            m = 32767;
        mag = m < 0 ? -m : m;
        if (mag < longint'(deadzone))
            m = 0;
        return m;
    endfunction

    function longint round_away(longint n, longint q);
        if (n >= 0)
            return (n + q / 2) / q;
        return -((-n + q / 2) / q);
    endfunction

    function void note_command(tca_pkg::cmd_t c);
        longint axis [6];
        longint thrust [6];
        longint peak;
        longint den;
        longint span;
        logic [11:0] width [6];
        tca_pkg::pulse_t p;
        axis[0] = scale_byte(c.cmd_surge);
        axis[1] = scale_byte(c.cmd_sway);
        axis[2] = scale_byte(c.cmd_heave);
        axis[3] = scale_byte(c.cmd_roll);
        axis[4] = scale_byte(c.cmd_pitch);
        axis[5] = scale_byte(c.cmd_yaw);
        peak = 0;
        for (int i = 0; i < 6; i++)
        begin
            thrust[i] = 0;
            for (int j = 0; j < 6; j++)
                thrust[i] += longint'(tca_pkg::ALLOC[i][j]) * axis[j];
            if ((thrust[i] < 0 ? -thrust[i] : thrust[i]) > peak)
                peak = thrust[i] < 0 ? -thrust[i] : thrust[i];
        end
        den = longint'(1) << 28;
        if (peak > den)
            den = peak;
        span = longint'(max_us) - longint'(min_us);
        for (int i = 0; i < 6; i++)
            width[i] = 12'(longint'(min_us) + round_away((thrust[i] + den) * span, 2 * den));
        p.pulse_0 = width[0];
        p.pulse_1 = width[1];
        p.pulse_2 = width[2];
        p.pulse_3 = width[3];
        p.pulse_4 = width[4];
        p.pulse_5 = width[5];
        expected_q.push_back(p);
    endfunction

    function void check_pulse(tca_pkg::pulse_t got);
        tca_pkg::pulse_t e;
        if (expected_q.size() == 0)
        begin
            $error("unexpected pulse transaction %h", got);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.pulse_0 !== e.pulse_0)
        begin
            $error("pulse_0 expected %0d actual %0d", e.pulse_0, got.pulse_0);
            errors++;
        end
        if (got.pulse_1 !== e.pulse_1)
        begin
            $error("pulse_1 expected %0d actual %0d", e.pulse_1, got.pulse_1);
            errors++;
        end
        if (got.pulse_2 !== e.pulse_2)
        begin
            $error("pulse_2 expected %0d actual %0d", e.pulse_2, got.pulse_2);
            errors++;
        end
        if (got.pulse_3 !== e.pulse_3)
        begin
            $error("pulse_3 expected %0d actual %0d", e.pulse_3, got.pulse_3);
            errors++;
        end
        if (got.pulse_4 !== e.pulse_4)
        begin
            $error("pulse_4 expected %0d actual %0d", e.pulse_4, got.pulse_4);
            errors++;
        end
        if (got.pulse_5 !== e.pulse_5)
        begin
            $error("pulse_5 expected %0d actual %0d", e.pulse_5, got.pulse_5);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import tca_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic pulse_valid;
    logic pulse_stall = 1'b0;
    pulse_t pulse;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pulse_scoreboard board = new();
    bit quiet = 1'b0;
    int hold_cycles = 0;
    int stall_left = 0;

    thruster_control_allocation uut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: random stall bursts, or a long hold when asked, and no stalls when quiet
    always @(posedge clk)
    begin
        if (rst_n && pulse_valid && !pulse_stall)
            board.check_pulse(pulse);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pulse_stall <= 1'b1;
        end
        else if (quiet)
            pulse_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pulse_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= int'($urandom_range(0, 5));
            pulse_stall <= 1'b1;
        end
        else
            pulse_stall <= 1'b0;
    end

    task automatic send_cmd(cmd_t c);
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_command(c);
    endtask

    task automatic gap();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 6);
            cmd_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [14:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_reg(idx, value);
    endtask

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c = cmd_t'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
        begin
            c.cmd_surge = 8'(128 + $urandom_range(0, 8) - 4);
            c.cmd_yaw = 8'(128 + $urandom_range(0, 8) - 4);
        end
        return c;
    endfunction

    initial
    begin
        cmd_t d;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        d = '0;
        send_cmd(d);
        send_cmd('1);
        send_cmd({6{8'd128}});
        send_cmd({6{8'd127}});
        send_cmd({6{8'd255}});
        for (int a = 0; a < 6; a++)
        begin
            d = {6{8'd128}};
            d[8*a +: 8] = 8'd255;
            send_cmd(d);
            d[8*a +: 8] = 8'd0;
            send_cmd(d);
        end
        send_cmd({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
        send_cmd({8'd134, 8'd121, 8'd140, 8'd116, 8'd200, 8'd60});
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                1: begin write_reg(CFG_DEADZONE, 15'd0); write_reg(CFG_MIN_PULSE, 15'd0);
                         write_reg(CFG_MAX_PULSE, 15'd4095); end
                2: begin write_reg(CFG_DEADZONE, 15'd32767); end
                3: begin write_reg(CFG_DEADZONE, 15'd8000); write_reg(CFG_MIN_PULSE, 15'd4095);
                         write_reg(CFG_MAX_PULSE, 15'd0); end
                4: begin write_reg(CFG_DEADZONE, 15'h7fff & 15'($urandom));
                         write_reg(CFG_MIN_PULSE, 15'h7fff & 15'($urandom));
                         write_reg(CFG_MAX_PULSE, 15'h7fff & 15'($urandom)); end
                5: begin write_reg(CFG_MIN_PULSE, 15'd1500); write_reg(CFG_MAX_PULSE, 15'd1500);
                         write_reg(CFG_DEADZONE, 15'd257); end
                6: begin write_reg(CFG_DEADZONE, 15'd1638); write_reg(CFG_MIN_PULSE, 15'd1100);
                         write_reg(CFG_MAX_PULSE, 15'd1900); end
                7: begin quiet = 1'b1; write_reg(CFG_DEADZONE, 15'd1638);
                         write_reg(CFG_MIN_PULSE, 15'd1000);
                         write_reg(CFG_MAX_PULSE, 15'd2000); end
                default: ;
            endcase
            if (phase == 2)
                hold_cycles = 60;
            for (int k = 0; k < 240; k++)
            begin
                send_cmd(rand_cmd());
                gap();
            end
            drain();
        end

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
